// ----- design/ppid_pkg.sv -----
package ppid_pkg;

	// What one item asks of the controller, decided at the front stage.
	typedef enum logic [1:0] {
		KIND_STEP,
		KIND_HOLD,
		KIND_OFF,
		KIND_CLEAR
	} step_kind_t;

	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_GAIN_P    = 3'd0;
	localparam cfg_idx_t CFG_GAIN_I    = 3'd1;
	localparam cfg_idx_t CFG_GAIN_D    = 3'd2;
	localparam cfg_idx_t CFG_BIAS      = 3'd3;
	localparam cfg_idx_t CFG_OUT_LIM   = 3'd4;
	localparam cfg_idx_t CFG_INT_LIM   = 3'd5;
	localparam cfg_idx_t CFG_ERR_WIN   = 3'd6;
	localparam cfg_idx_t CFG_MODE      = 3'd7;

	localparam logic [63:0] OUT_LIM_RST = 64'h0001_0000_FFFF_0000;
	localparam logic [63:0] INT_LIM_RST = 64'h7FFF_FFFF_8000_0000;
	localparam logic [63:0] ERR_WIN_RST = 64'h7FFF_FFFF_0000_0000;

	localparam int MODE_OFF_BIT = 0;
	localparam int MODE_SC_BIT  = 1;

	// Side information that travels with an item through the product stages.
	typedef struct packed {
		step_kind_t  kind;
		logic        win;
		logic        sc;
		logic [31:0] err_now;
	} step_tag_t;

	// Stage enables for the rounded multiplier.
	typedef struct packed {
		logic load_prod;
		logic load_rnd;
	} qmul_ctl_t;

endpackage

// ----- design/ppid_qmul.sv -----
module ppid_qmul #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  ppid_pkg::qmul_ctl_t          ctl,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output logic signed [DATA_WIDTH-1:0] rnd_s4
);
	import ppid_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int PW = 2 * DW + 1;
	localparam logic signed [PW-1:0] HALF = {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic signed [PW-1:0] QMAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [PW-1:0] QMIN = ~QMAX;

	logic signed [2*DW-1:0] prod_s3;
	logic signed [PW-1:0]   prod_x;
	logic signed [PW-1:0]   biased;
	logic signed [PW-1:0]   shifted;
	logic signed [DW-1:0]   rnd_d;

	always_ff @(posedge clk) begin
		if (ctl.load_prod) begin
			prod_s3 <= a * b;
		end
		if (ctl.load_rnd) begin
			rnd_s4 <= rnd_d;
		end
	end

	// Round half away from zero: a negative product takes half minus one.
	always_comb begin
		prod_x  = {prod_s3[2*DW-1], prod_s3};
		biased  = prod_s3[2*DW-1] ? (prod_x + HALF - PW'(1)) : (prod_x + HALF);
		shifted = biased >>> FRAC_BITS;
		if (shifted > QMAX) begin
			rnd_d = QMAX[DW-1:0];
		end else if (shifted < QMIN) begin
			rnd_d = QMIN[DW-1:0];
		end else begin
			rnd_d = shifted[DW-1:0];
		end
	end

endmodule

// ----- design/positional_pid_step.sv -----
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: measurement, setpoint, sample_due; s_tuser: func
// m_        out  m_tvalid/m_tready  m_tdata: drive, error_now
// cfg_      in   cfg_we             cfg_index, cfg_data (no read-back)
//
// One item per clock when the output is taken; an accepted item passes through the
// input, error, product, rounding and result registers.
// The integral and held drive update in stage 4, one item per cycle when the output is taken.
// arst_n clears the valid bits and controller state and loads the register defaults.
// With m_tready low the result holds and the four earlier stages keep filling
// until all are full; s_tready then drops.
module positional_pid_step #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [71:0]        s_tdata,   // [31:0] measurement, [63:32] setpoint, [64] sample_due
	input  logic [0:0]         s_tuser,   // [0] func
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata,   // [31:0] drive, [63:32] error_now
	input  logic               cfg_we,
	input  ppid_pkg::cfg_idx_t cfg_index,
	input  logic [63:0]        cfg_data
);
	import ppid_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int WW = (DW > 32) ? DW : 32;
	localparam int XW = WW + 2;
	localparam logic signed [XW-1:0] DMAX_X = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [XW-1:0] DMIN_X = ~DMAX_X;
	localparam logic signed [XW-1:0] O32MAX_X = {{(XW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [XW-1:0] O32MIN_X = ~O32MAX_X;

	// ---------------------------------------------------------------
	// Fixed-point helpers
	// ---------------------------------------------------------------
	function automatic logic signed [XW-1:0] ext_d(input logic signed [DW-1:0] v);
		return {{(XW-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic signed [XW-1:0] ext_32(input logic [31:0] v);
		return {{(XW-32){v[31]}}, v};
	endfunction

	function automatic logic signed [DW-1:0] sat_d(input logic signed [XW-1:0] v);
		if (v > DMAX_X) begin
			return DMAX_X[DW-1:0];
		end else if (v < DMIN_X) begin
			return DMIN_X[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] opnd(input logic [31:0] v);
		return sat_d(ext_32(v));
	endfunction

	function automatic logic [31:0] out32(input logic signed [DW-1:0] v);
		logic signed [XW-1:0] x;
		x = ext_d(v);
		if (x > O32MAX_X) begin
			x = O32MAX_X;
		end else if (x < O32MIN_X) begin
			x = O32MIN_X;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [DW-1:0] clamp_d(input logic signed [XW-1:0] v,
			input logic signed [DW-1:0] lo, input logic signed [DW-1:0] hi);
		logic signed [XW-1:0] lx;
		logic signed [XW-1:0] hx;
		lx = ext_d(lo);
		hx = ext_d(hi);
		if (v < lx) begin
			return lo;
		end else if (v > hx) begin
			return hi;
		end
		return v[DW-1:0];
	endfunction

	// Limit pairs: swap when the minimum half exceeds the maximum half.
	function automatic logic signed [DW-1:0] lim_lo(input logic [63:0] r);
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		a = opnd(r[31:0]);
		b = opnd(r[63:32]);
		return (a > b) ? b : a;
	endfunction

	function automatic logic signed [DW-1:0] lim_hi(input logic [63:0] r);
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		a = opnd(r[31:0]);
		b = opnd(r[63:32]);
		return (a > b) ? a : b;
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [31:0] gain_p_q;
	logic [31:0] gain_i_q;
	logic [31:0] gain_d_q;
	logic [31:0] bias_q;
	logic [63:0] out_lim_q;
	logic [63:0] int_lim_q;
	logic [63:0] err_win_q;
	logic [1:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			bias_q    <= '0;
			out_lim_q <= OUT_LIM_RST;
			int_lim_q <= INT_LIM_RST;
			err_win_q <= ERR_WIN_RST;
			mode_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_P:  gain_p_q  <= cfg_data[31:0];
				CFG_GAIN_I:  gain_i_q  <= cfg_data[31:0];
				CFG_GAIN_D:  gain_d_q  <= cfg_data[31:0];
				CFG_BIAS:    bias_q    <= cfg_data[31:0];
				CFG_OUT_LIM: out_lim_q <= cfg_data;
				CFG_INT_LIM: int_lim_q <= cfg_data;
				CFG_ERR_WIN: err_win_q <= cfg_data;
				CFG_MODE:    mode_q    <= cfg_data[1:0];
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake: each stage advances when the next one is free or moving
	// ---------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic adv_out, rdy4, rdy3, rdy2, rdy1;
	logic mv1, mv2, mv3, mv4, acc;

	always_comb begin
		adv_out = !out_vld_q || m_tready;
		mv4     = vld_s4 && adv_out;
		rdy4    = !vld_s4 || adv_out;
		mv3     = vld_s3 && rdy4;
		rdy3    = !vld_s3 || rdy4;
		mv2     = vld_s2 && rdy3;
		rdy2    = !vld_s2 || rdy3;
		mv1     = vld_s1 && rdy2;
		rdy1    = !vld_s1 || rdy2;
		acc     = s_tvalid && rdy1;
	end

	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1    <= acc ? 1'b1 : (mv1 ? 1'b0 : vld_s1);
			vld_s2    <= mv1 ? 1'b1 : (mv2 ? 1'b0 : vld_s2);
			vld_s3    <= mv2 ? 1'b1 : (mv3 ? 1'b0 : vld_s3);
			vld_s4    <= mv3 ? 1'b1 : (mv4 ? 1'b0 : vld_s4);
			out_vld_q <= mv4 ? 1'b1 : (m_tready ? 1'b0 : out_vld_q);
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic        func_s1;
	logic [31:0] meas_s1;
	logic [31:0] sp_s1;
	logic        due_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1 <= s_tuser[0];
			meas_s1 <= s_tdata[31:0];
			sp_s1   <= s_tdata[63:32];
			due_s1  <= s_tdata[64];
		end
	end

	// Front state: last measurement and last error of a due step. Both depend
	// only on inputs, so they update as the item leaves stage 1.
	logic signed [DW-1:0] pm_q;
	logic signed [DW-1:0] pe_q;

	step_kind_t           kind1;
	logic signed [DW-1:0] meas1, sp1, e1, diff1, pm_next, pe_next;
	logic signed [XW-1:0] sp_x, ae_x, e_x, wmin_x, wmax_x;
	step_tag_t            tag1;

	always_comb begin
		meas1 = opnd(meas_s1);
		sp1   = opnd(sp_s1);

		// Clear wins over disable, disable over the sample-due test.
		priority if (func_s1) begin
			kind1 = KIND_CLEAR;
		end else if (mode_q[MODE_OFF_BIT]) begin
			kind1 = KIND_OFF;
		end else if (!due_s1) begin
			kind1 = KIND_HOLD;
		end else begin
			kind1 = KIND_STEP;
		end

		diff1 = sat_d(ext_d(meas1) - ext_d(pm_q));
		e1    = sat_d(ext_d(sp1) - ext_d(meas1));

		// Error window test is exact, against the raw 32-bit window bounds.
		sp_x   = ext_d(sp1);
		e_x    = ext_d(e1);
		ae_x   = e_x[XW-1] ? -e_x : e_x;
		wmin_x = ext_32(err_win_q[31:0]);
		wmax_x = ext_32(err_win_q[63:32]);

		unique case (kind1)
			KIND_CLEAR: begin
				pm_next = '0;
				pe_next = '0;
			end
			KIND_STEP: begin
				pm_next = meas1;
				pe_next = e1;
			end
			KIND_HOLD, KIND_OFF: begin
				pm_next = pm_q;
				pe_next = pe_q;
			end
		endcase

		tag1.kind    = kind1;
		tag1.win     = ((ae_x < sp_x - wmin_x) && (ae_x > sp_x - wmax_x)) ||
			((ae_x > sp_x + wmin_x) && (ae_x < sp_x + wmax_x));
		// Zero counts as positive for the sign-change test.
		tag1.sc      = mode_q[MODE_SC_BIT] && (e1[DW-1] != pe_q[DW-1]);
		tag1.err_now = out32(sat_d(sp_x - ext_d(pm_next)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q <= '0;
			pe_q <= '0;
		end else if (mv1) begin
			pm_q <= pm_next;
			pe_q <= pe_next;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: error and measurement difference, then products
	// ---------------------------------------------------------------
	logic signed [DW-1:0] e_s2;
	logic signed [DW-1:0] diff_s2;
	step_tag_t            tag_s2, tag_s3, tag_s4;

	always_ff @(posedge clk) begin
		if (mv1) begin
			e_s2    <= e1;
			diff_s2 <= diff1;
			tag_s2  <= tag1;
		end
		if (mv2) begin
			tag_s3 <= tag_s2;
		end
		if (mv3) begin
			tag_s4 <= tag_s3;
		end
	end

	qmul_ctl_t            qctl;
	logic signed [DW-1:0] gp_op, gi_op, gd_op, bias_op;
	logic signed [DW-1:0] pp_s4, pi_s4, pd_s4;

	always_comb begin
		qctl.load_prod = mv2;
		qctl.load_rnd  = mv3;
		gp_op          = opnd(gain_p_q);
		gi_op          = opnd(gain_i_q);
		gd_op          = opnd(gain_d_q);
		bias_op        = opnd(bias_q);
	end

	ppid_qmul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_qmul_p (
		.clk    (clk),
		.ctl    (qctl),
		.a      (gp_op),
		.b      (e_s2),
		.rnd_s4 (pp_s4)
	);

	ppid_qmul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_qmul_i (
		.clk    (clk),
		.ctl    (qctl),
		.a      (gi_op),
		.b      (e_s2),
		.rnd_s4 (pi_s4)
	);

	ppid_qmul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_qmul_d (
		.clk    (clk),
		.ctl    (qctl),
		.a      (gd_op),
		.b      (diff_s2),
		.rnd_s4 (pd_s4)
	);

	// ---------------------------------------------------------------
	// Stage 4: integral and drive update, a loop-carried path
	// ---------------------------------------------------------------
	logic signed [DW-1:0] integ_q;
	logic signed [DW-1:0] dh_q;
	logic signed [XW-1:0] integ_acc, sum_x;
	logic signed [DW-1:0] integ_new, drive_new, drive4;

	always_comb begin
		integ_acc = tag_s4.win ? (ext_d(integ_q) + ext_d(pi_s4)) : ext_d(integ_q);
		if (tag_s4.sc) begin
			integ_acc = '0;
		end
		integ_new = clamp_d(integ_acc, lim_lo(int_lim_q), lim_hi(int_lim_q));
		sum_x     = ext_d(pp_s4) + ext_d(integ_new) - ext_d(pd_s4) + ext_d(bias_op);
		drive_new = clamp_d(sum_x, lim_lo(out_lim_q), lim_hi(out_lim_q));

		unique case (tag_s4.kind)
			KIND_STEP:            drive4 = drive_new;
			KIND_HOLD:            drive4 = dh_q;
			KIND_OFF, KIND_CLEAR: drive4 = '0;
		endcase
	end

	// A limit write pulls the stored value into the new range; the user must
	// write only while no item is in flight, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			dh_q    <= '0;
		end else if (cfg_we && (cfg_index == CFG_OUT_LIM)) begin
			dh_q <= clamp_d(ext_d(dh_q), lim_lo(cfg_data), lim_hi(cfg_data));
		end else if (cfg_we && (cfg_index == CFG_INT_LIM)) begin
			integ_q <= clamp_d(ext_d(integ_q), lim_lo(cfg_data), lim_hi(cfg_data));
		end else if (mv4 && (tag_s4.kind == KIND_CLEAR)) begin
			integ_q <= '0;
			dh_q    <= '0;
		end else if (mv4 && (tag_s4.kind == KIND_STEP)) begin
			integ_q <= integ_new;
			dh_q    <= drive_new;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic [63:0] res_q;

	always_ff @(posedge clk) begin
		if (mv4) begin
			res_q <= {tag_s4.err_now, out32(drive4)};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = res_q;

endmodule

// ----- design/ppid_check.sv -----
module ppid_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	localparam logic [3:0] CAP = 4'd5;

	logic [3:0] infl_q;

	// Count items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q <= '0;
		end else begin
			infl_q <= infl_q + 4'(s_tvalid && s_tready) - 4'(m_tvalid && m_tready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled although the result side is free");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (infl_q != 4'd0))
		else $error("result shown with no item in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		infl_q <= CAP)
		else $error("more items in flight than pipeline stages");

endmodule

bind positional_pid_step ppid_check u_ppid_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
